### rtl/core/gcm_pkg.sv
// Package for the GCM mode core: command codes, register indexes and shared types.
// Used by every module in rtl/core; depends on nothing.
package gcm_pkg;

  typedef enum logic [2:0] {
    CmdStart     = 3'd0,
    CmdAad       = 3'd1,
    CmdEncrypt   = 3'd2,
    CmdDecrypt   = 3'd3,
    CmdFinishEnc = 3'd4,
    CmdFinishDec = 3'd5,
    CmdRsvd6     = 3'd6,
    CmdRsvd7     = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    RegKeyHi = 3'd0,
    RegKeyLo = 3'd1,
    RegPreHi = 3'd2,
    RegPreLo = 3'd3,
    RegTagBytes = 3'd4
  } reg_e;

  localparam int unsigned BlockBits = 128;
  localparam int unsigned QueueDepth = 2;

  // Classified request as it travels from the front part to the back part.
  typedef struct packed {
    cmd_e         cmd;
    logic [127:0] data;
    logic [127:0] stream;
    logic [127:0] mask;
    logic [4:0]   nbytes;
  } req_t;

  typedef struct packed {
    logic [127:0] result;
    logic [31:0]  next_counter;
    logic         tag_match;
  } rsp_t;

  // Mask that keeps the leading n bytes of a big-endian 128-bit block.
  function automatic logic [127:0] lead_mask(input logic [4:0] n);
    logic [127:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < n) m[127 - 8*i -: 8] = 8'hFF;
    end
    return m;
  endfunction

  // One full GF(2^128) product with GCM bit order.
  function automatic logic [127:0] gf_mult(input logic [127:0] x, input logic [127:0] h);
    logic [127:0] z;
    logic [127:0] v;
    z = '0;
    v = h;
    for (int i = 0; i < 128; i++) begin
      if (x[127 - i]) z = z ^ v;
      v = v[0] ? ((v >> 1) ^ {8'hE1, 120'd0}) : (v >> 1);
    end
    return z;
  endfunction

endpackage

### rtl/core/gcm_mode_ghash_counter.sv
// Top level of the GCM mode core: configuration registers, front and back parts.
// Depends on gcm_pkg, gcm_front and gcm_back.
//
//  channel   | handshake      | payload
//  input     | push / full    | command, block, stream, valid_bytes
//  result    | pop / empty    | result, next_counter, tag_match
//  config    | cfg_we_i       | cfg_index_i, cfg_data_i
//
// Each request is finished in the back part with one full GF(2^128) multiply; one request
// per cycle is sustained while results are popped.
// A pushed request is registered in the two-entry request queue, then its result in the result register.
// Reset empties the queue and the result register and clears all hash state; tag_bytes resets to 16.
// A held result stalls the back part, and the queue then stalls the input.
module gcm_mode_ghash_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command_i,
  input  logic [63:0] block_hi_i,
  input  logic [63:0] block_lo_i,
  input  logic [63:0] stream_hi_i,
  input  logic [63:0] stream_lo_i,
  input  logic [4:0]  valid_bytes_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] result_hi_o,
  output logic [63:0] result_lo_o,
  output logic [31:0] next_counter_o,
  output logic        tag_match_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import gcm_pkg::*;

  logic [63:0] key_hi_q, key_lo_q;
  logic [31:0] pre_lo_q;
  logic [4:0]  tag_bytes_q;
  logic        req_valid, req_ready;
  req_t        req;
  rsp_t        rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q    <= '0;
      key_lo_q    <= '0;
      pre_lo_q    <= '0;
      tag_bytes_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        RegKeyHi:    key_hi_q    <= cfg_data_i;
        RegKeyLo:    key_lo_q    <= cfg_data_i;
        RegPreLo:    pre_lo_q    <= cfg_data_i[31:0];
        RegTagBytes: tag_bytes_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  gcm_front u_front (
    .clk_i, .rst_ni, .push, .full, .command_i, .block_hi_i, .block_lo_i,
    .stream_hi_i, .stream_lo_i, .valid_bytes_i,
    .req_valid_o(req_valid), .req_o(req), .req_ready_i(req_ready)
  );

  gcm_back u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_i(req), .req_ready_o(req_ready),
    .hash_key_i({key_hi_q, key_lo_q}), .seed_i(pre_lo_q),
    .tag_bytes_i(tag_bytes_q), .empty, .pop, .rsp_o(rsp)
  );

  assign result_hi_o    = rsp.result[127:64];
  assign result_lo_o    = rsp.result[63:0];
  assign next_counter_o = rsp.next_counter;
  assign tag_match_o    = rsp.tag_match;

`ifndef SYNTHESIS
  a_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cfg_we_i && cfg_index_i == RegTagBytes) |-> tag_bytes_q == $past(cfg_data_i[4:0]))
    else $error("tag_bytes write lost");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !req_valid) |=> empty) else $error("result not released");
  a_key_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(key_hi_q) && $stable(key_lo_q)) else $error("key changed");
`endif
endmodule

### rtl/core/gcm_front.sv
// Front part of the GCM core: accepts requests, clamps the byte count and builds masks.
// Depends on gcm_pkg.
module gcm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [2:0]      command_i,
  input  logic [63:0]     block_hi_i,
  input  logic [63:0]     block_lo_i,
  input  logic [63:0]     stream_hi_i,
  input  logic [63:0]     stream_lo_i,
  input  logic [4:0]      valid_bytes_i,
  output logic            req_valid_o,
  output gcm_pkg::req_t   req_o,
  input  logic            req_ready_i
);
  import gcm_pkg::*;

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  req_t                 fifo_q [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]     count_q, count_d;
  logic [4:0]           nb;
  req_t                 req_in;
  logic                 do_wr, do_rd;

  always_comb begin
    nb = valid_bytes_i;
    if (nb == 5'd0) nb = 5'd1;
    if (nb > 5'd16) nb = 5'd16;
    req_in.cmd    = cmd_e'(command_i);
    req_in.data   = {block_hi_i, block_lo_i};
    req_in.stream = {stream_hi_i, stream_lo_i};
    req_in.mask   = lead_mask(nb);
    req_in.nbytes = nb;
  end

  assign full        = (count_q == (PtrBits+1)'(QueueDepth));
  assign do_wr       = push && !full;
  assign req_valid_o = (count_q != '0);
  assign do_rd       = req_valid_o && req_ready_i;
  assign req_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrBits+1)'(do_wr) - (PtrBits+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) fifo_q[wr_ptr_q] <= req_in;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrBits+1)'(QueueDepth)) else $error("request queue overflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> count_q == $past(count_q) + 1'b1) else $error("count step");
  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rd |-> count_q != '0) else $error("read from empty queue");
`endif
endmodule

### rtl/core/gcm_back.sv
// Back part of the GCM core: keystream XOR, GHASH update, lengths, tag and result register.
// Depends on gcm_pkg.
module gcm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  gcm_pkg::req_t   req_i,
  output logic            req_ready_o,
  input  logic [127:0]    hash_key_i,
  input  logic [31:0]     seed_i,
  input  logic [4:0]      tag_bytes_i,
  output logic            empty,
  input  logic            pop,
  output gcm_pkg::rsp_t   rsp_o
);
  import gcm_pkg::*;

  logic [127:0] acc_q, acc_d;
  logic [31:0]  ctr_q, ctr_d;
  logic [63:0]  aad_len_q, aad_len_d, pay_len_q, pay_len_d;
  rsp_t         out_q, rsp_d;
  logic         out_valid_q;
  logic         take;
  logic [127:0] gf_in, prod, xr, tag, tmask;
  logic [4:0]   tb;
  logic [63:0]  add_bits;

  assign req_ready_o = !out_valid_q || pop;
  assign take        = req_valid_i && req_ready_o;
  assign empty       = !out_valid_q;
  assign rsp_o       = out_q;
  assign add_bits    = {56'd0, req_i.nbytes, 3'd0};

  always_comb begin
    xr = (req_i.data ^ req_i.stream) & req_i.mask;
    case (req_i.cmd)
      CmdAad, CmdDecrypt: gf_in = acc_q ^ (req_i.data & req_i.mask);
      CmdEncrypt:         gf_in = acc_q ^ xr;
      default:            gf_in = acc_q ^ {aad_len_q, pay_len_q};
    endcase
    prod = gf_mult(gf_in, hash_key_i);
    tag  = prod ^ req_i.stream;
    tb   = tag_bytes_i;
    if (tb < 5'd4) tb = 5'd4;
    if (tb > 5'd16) tb = 5'd16;
    tmask = lead_mask(tb);

    acc_d     = acc_q;
    ctr_d     = ctr_q;
    aad_len_d = aad_len_q;
    pay_len_d = pay_len_q;
    rsp_d     = '0;
    case (req_i.cmd)
      CmdStart: begin
        acc_d     = '0;
        aad_len_d = '0;
        pay_len_d = '0;
        ctr_d     = seed_i;
      end
      CmdAad: begin
        acc_d     = prod;
        aad_len_d = aad_len_q + add_bits;
      end
      CmdEncrypt, CmdDecrypt: begin
        acc_d        = prod;
        ctr_d        = ctr_q + 32'd1;
        pay_len_d    = pay_len_q + add_bits;
        rsp_d.result = xr;
      end
      CmdFinishEnc: rsp_d.result = tag;
      CmdFinishDec: begin
        rsp_d.result    = tag;
        rsp_d.tag_match = (((req_i.data ^ tag) & tmask) == '0);
      end
      default: ;
    endcase
    rsp_d.next_counter = ctr_d + 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ctr_q       <= '0;
      aad_len_q   <= '0;
      pay_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        acc_q     <= acc_d;
        ctr_q     <= ctr_d;
        aad_len_q <= aad_len_d;
        pay_len_q <= pay_len_d;
      end
      if (take) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= rsp_d;
  end

`ifndef SYNTHESIS
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && req_i.cmd == CmdStart) |=> acc_q == '0 && aad_len_q == '0)
    else $error("start did not clear state");
  a_finish_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (req_i.cmd == CmdFinishEnc || req_i.cmd == CmdFinishDec)) |=> $stable(acc_q))
    else $error("finish changed accumulator");
  a_match_only_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && req_i.cmd != CmdFinishDec) |=> !out_q.tag_match)
    else $error("tag match outside finish-decrypt");
`endif
endmodule

### tb/sv/gcm_mode_ghash_counter_test.sv
// Self-checking testbench for gcm_mode_ghash_counter: directed extremes, then random GCM sessions with random idling.
// Depends on gcm_pkg and the gcm_mode_ghash_counter RTL.
module gcm_mode_ghash_counter_test;
  import gcm_pkg::*;

  typedef struct packed {
    logic [127:0] data;
    logic [31:0]  next_counter;
    logic         tag_match;
  } gcm_out_t;

  class gcm_scoreboard;
    logic [127:0] hash_key, precounter, accum;
    logic [31:0]  ctr;
    logic [63:0]  aad_bits, text_bits;
    logic [4:0]   tag_len;
    gcm_out_t     pending[$];
    int           errors;

    function new();
      hash_key = '0; precounter = '0; accum = '0; ctr = '0;
      aad_bits = '0; text_bits = '0; tag_len = 5'd16; errors = 0;
    endfunction

    function logic [127:0] byte_mask(input int n);
      logic [127:0] m;
      m = '0;
      for (int i = 0; i < 16; i++) if (i < n) m[127 - 8*i -: 8] = 8'hFF;
      return m;
    endfunction

    function logic [127:0] gf_times_h(input logic [127:0] x);
      logic [127:0] z, v;
      z = '0;
      v = hash_key;
      for (int i = 0; i < 128; i++) begin
        if (x[127 - i]) z ^= v;
        v = v[0] ? ((v >> 1) ^ {8'hE1, 120'd0}) : (v >> 1);
      end
      return z;
    endfunction

    function void write_reg(input reg_e idx, input logic [63:0] v);
      case (idx)
        RegKeyHi: hash_key[127:64] = v;
        RegKeyLo: hash_key[63:0] = v;
        RegPreHi: precounter[127:64] = v;
        RegPreLo: precounter[63:0] = v;
        RegTagBytes: tag_len = v[4:0];
        default: ;
      endcase
    endfunction

    function void note_request(input cmd_e cmd, input logic [127:0] blk,
                               input logic [127:0] strm, input logic [4:0] vb);
      int n, tb;
      logic [127:0] m, r, tm;
      gcm_out_t o;
      n = (vb == 0) ? 1 : (vb > 16 ? 16 : vb);
      m = byte_mask(n);
      r = '0;
      o.tag_match = 1'b0;
      case (cmd)
        CmdStart: begin
          accum = '0; aad_bits = '0; text_bits = '0; ctr = precounter[31:0];
        end
        CmdAad: begin
          accum = gf_times_h(accum ^ (blk & m));
          aad_bits += 64'(8 * n);
        end
        CmdEncrypt, CmdDecrypt: begin
          ctr += 32'd1;
          r = (blk ^ strm) & m;
          accum = gf_times_h(accum ^ (cmd == CmdEncrypt ? r : (blk & m)));
          text_bits += 64'(8 * n);
        end
        CmdFinishEnc, CmdFinishDec: begin
          r = gf_times_h(accum ^ {aad_bits, text_bits}) ^ strm;
          if (cmd == CmdFinishDec) begin
            tb = (tag_len < 4) ? 4 : (tag_len > 16 ? 16 : tag_len);
            tm = byte_mask(tb);
            o.tag_match = ((blk ^ r) & tm) == '0;
          end
        end
        default: ;
      endcase
      o.data = r;
      o.next_counter = ctr + 32'd1;
      pending.push_back(o);
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(input gcm_out_t got);
      gcm_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data)
        report_mismatch($sformatf("data %h, wanted %h", got.data, want.data));
      if (got.next_counter !== want.next_counter)
        report_mismatch($sformatf("next_counter %h, wanted %h",
                                  got.next_counter, want.next_counter));
      if (got.tag_match !== want.tag_match)
        report_mismatch($sformatf("tag_match %b, wanted %b", got.tag_match, want.tag_match));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  command_i = '0;
  logic [63:0] block_hi_i = '0, block_lo_i = '0, stream_hi_i = '0, stream_lo_i = '0;
  logic [4:0]  valid_bytes_i = 5'd16;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] result_hi_o, result_lo_o;
  logic [31:0] next_counter_o;
  logic        tag_match_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  gcm_scoreboard sb = new();
  bit            pop_always = 1'b0;

  gcm_mode_ghash_counter DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_reg(input reg_e idx, input logic [63:0] v);
    push <= 1'b0;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // The request stays driven after acceptance; a following request with no
  // gap replaces it, and anything else drops push first.
  task automatic send_request(input cmd_e cmd, input logic [127:0] blk,
                              input logic [127:0] strm, input logic [4:0] vb,
                              input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11));
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    {block_hi_i, block_lo_i} <= blk;
    {stream_hi_i, stream_lo_i} <= strm;
    valid_bytes_i <= vb;
    do @(posedge clk_i); while (full);
    sb.note_request(cmd, blk, strm, vb);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: random stall before each pop, with stretches of none.
  initial begin
    int stall;
    gcm_out_t got;
    forever begin
      stall = (pop_always || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do begin
        @(posedge clk_i);
        if (!empty) begin
          got.data = {result_hi_o, result_lo_o};
          got.next_counter = next_counter_o;
          got.tag_match = tag_match_o;
          sb.check_result(got);
        end
      end while (empty);
    end
  end

  task automatic random_session(input bit bursty);
    int n_aad, n_txt;
    cmd_e dir;
    logic [127:0] strm;
    dir = $urandom_range(0, 1) ? CmdEncrypt : CmdDecrypt;
    send_request(CmdStart, {rand64(), rand64()}, {rand64(), rand64()}, 5'($urandom), bursty);
    n_aad = $urandom_range(0, 4);
    n_txt = $urandom_range(0, 6);
    for (int i = 0; i < n_aad; i++)
      send_request(CmdAad, {rand64(), rand64()}, {rand64(), rand64()},
                   (i == n_aad - 1 && $urandom_range(0, 1)) ? 5'($urandom) : 5'd16, bursty);
    for (int i = 0; i < n_txt; i++)
      send_request(dir, {rand64(), rand64()}, {rand64(), rand64()},
                   (i == n_txt - 1 && $urandom_range(0, 1)) ? 5'($urandom) : 5'd16, bursty);
    strm = {rand64(), rand64()};
    if ($urandom_range(0, 1))
      send_request(CmdFinishEnc, {rand64(), rand64()}, strm, 5'($urandom), bursty);
    else begin
      // Predict the tag and send it back, sometimes with a flipped bit.
      begin
        logic [127:0] tag;
        tag = sb.gf_times_h(sb.accum ^ {sb.aad_bits, sb.text_bits}) ^ strm;
        if ($urandom_range(0, 2) == 0) tag[$urandom_range(0, 127)] ^= 1'b1;
        send_request(CmdFinishDec, tag, strm, 5'($urandom), bursty);
      end
    end
    if ($urandom_range(0, 9) == 0)
      send_request(cmd_e'($urandom_range(0, 7)), {rand64(), rand64()},
                   {rand64(), rand64()}, 5'($urandom), bursty);
  endtask

  initial begin
    int sent;
    logic [127:0] ones, t;
    ones = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings first, then extremes.
    send_request(CmdFinishDec, '0, '0, 5'd16);
    drain();
    write_reg(RegKeyHi, 64'h66E94BD4EF8A2C3B);
    write_reg(RegKeyLo, 64'h884CFA59CA342B2E);
    write_reg(RegPreHi, '1);
    write_reg(RegPreLo, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(RegTagBytes, 64'd2);
    send_request(CmdStart, '0, '0, 5'd0);
    send_request(CmdAad, ones, '0, 5'd0);
    send_request(CmdAad, ones, ones, 5'd31);
    send_request(CmdAad, ones, ones, 5'd16);
    send_request(CmdEncrypt, ones, '0, 5'd16);
    send_request(CmdEncrypt, '0, ones, 5'd15);
    send_request(CmdDecrypt, ones, ones, 5'd1);
    send_request(CmdDecrypt, ones, '0, 5'd17);
    send_request(CmdRsvd6, ones, ones, 5'd3);
    send_request(CmdRsvd7, ones, ones, 5'd3);
    send_request(CmdFinishEnc, ones, ones, 5'd0);
    send_request(CmdFinishEnc, ones, ones, 5'd9);
    t = sb.gf_times_h(sb.accum ^ {sb.aad_bits, sb.text_bits}) ^ ones;
    send_request(CmdFinishDec, t, ones, 5'd0);
    t[3] ^= 1'b1;
    send_request(CmdFinishDec, t, ones, 5'd0);
    t[127] ^= 1'b1;
    send_request(CmdFinishDec, t, ones, 5'd0);
    drain();
    write_reg(RegTagBytes, 64'h1F);
    send_request(CmdFinishDec, t, ones, 5'd16);
    drain();
    write_reg(RegTagBytes, 64'd4);
    send_request(CmdFinishDec, t ^ 128'h1, ones, 5'd16);
    drain();

    // Random sessions in phases, each with fresh settings.
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      pop_always = (ph == 3);
      write_reg(RegKeyHi, ph == 1 ? 64'h0 : rand64());
      write_reg(RegKeyLo, ph == 1 ? 64'h1 : rand64());
      write_reg(RegPreHi, rand64());
      write_reg(RegPreLo, ph == 2 ? 64'hFFFF_FFFF : rand64());
      write_reg(RegTagBytes, ph == 0 ? 64'd0 : 64'($urandom_range(0, 31)));
      repeat (31) begin
        random_session(ph == 3 || ph == 5);
      end
      drain();
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end
endmodule

### gcm_mode_ghash_counter.f
rtl/core/gcm_pkg.sv
rtl/core/gcm_front.sv
rtl/core/gcm_back.sv
rtl/core/gcm_mode_ghash_counter.sv
tb/sv/gcm_mode_ghash_counter_test.sv
